[hw/rtl/tmba_pkg.sv]
// Shared types, codes and constants for the two-master bus arbiter unit.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package tmba_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int CMP_W        = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

  localparam logic [CFG_W-1:0] FORCE_AFTER_RESET   = CFG_W'(125);
  localparam logic [CFG_W-1:0] GIVE_UP_AFTER_RESET = CFG_W'(250);

  localparam logic [7:0] CTL_INIT     = 8'h10;
  localparam logic [7:0] CTL_REQ      = 8'h80;
  localparam logic [7:0] ST_OTHER_REQ = 8'h80;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_POLL    = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OUT_RETRY    = 3'd0,
    OUT_ACQUIRED = 3'd1,
    OUT_RDERR    = 3'd2,
    OUT_TIMEOUT  = 3'd3,
    OUT_NONE     = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    DLY_SHORT = 2'd0,
    DLY_LONG  = 2'd1,
    DLY_XLONG = 2'd2
  } delay_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FORCE_AFTER   = 1'b0,
    CFG_GIVE_UP_AFTER = 1'b1
  } cfg_index_t;

  typedef logic [7:0] cmd_table_t [16];
  localparam cmd_table_t CMD_TABLE = '{
    8'd4, 8'd0, 8'd1, 8'd5, 8'd4, 8'd4, 8'd5, 8'd5,
    8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd4, 8'd5, 8'd1
  };

  // a two-bit field reads as "off" when both bits agree
  function automatic logic pair_off(input logic [1:0] f);
    return f[1] == f[0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tmba_if.sv]
// Valid/ready channel interfaces for the arbiter's input and result transactions.
// No dependencies; field widths are written out as literals.
`default_nettype none

interface tmba_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] control_value;
  logic [7:0] status_value;
  logic       read_failed;

  modport source(output valid, mode, control_value, status_value, read_failed,
                 input ready);
  modport sink(input valid, mode, control_value, status_value, read_failed,
               output ready);
endinterface

interface tmba_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] write_data;
  logic [2:0] outcome;
  logic [1:0] retry_delay;

  modport source(output valid, write_enable, write_data, outcome, retry_delay,
                 input ready);
  modport sink(input valid, write_enable, write_data, outcome, retry_delay,
               output ready);
endinterface

`default_nettype wire

[hw/rtl/two_master_bus_arbiter_unit.sv]
// Two-master bus arbiter, requesting side: one result per input transaction.
// The result is valid in the cycle after acceptance; throughput 1 transaction
// per cycle, set by the single result register (input taken whenever that
// register is empty or being drained). Synchronous active-high reset clears
// the acquire flag, tick counter and result valid, and loads register defaults.
// Depends on tmba_pkg and tmba_if.
`default_nettype none

module two_master_bus_arbiter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tmba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tmba_pkg::CFG_W-1:0]       cfg_data,
  tmba_in_if.sink                               in_ch,
  tmba_out_if.source                            out_ch
);

  logic [tmba_pkg::CFG_W-1:0]        force_after;
  logic [tmba_pkg::CFG_W-1:0]        give_up_after;
  logic                              acquiring;
  logic                              acquiring_next;
  logic [tmba_pkg::COUNTER_BITS-1:0] elapsed;
  logic [tmba_pkg::COUNTER_BITS-1:0] elapsed_next;

  logic       out_valid;
  logic       out_we;
  logic [7:0] out_data;
  logic [2:0] out_outcome;
  logic [1:0] out_delay;

  logic                  we_next;
  logic [7:0]            data_next;
  tmba_pkg::outcome_t    outcome_next;
  tmba_pkg::delay_t      delay_next;

  logic                       accept;
  logic [7:0]                 ctl;
  logic                       on_off;
  logic                       own_off;
  logic [tmba_pkg::CMP_W-1:0] elapsed_x;
  logic                       forced;
  logic                       timed_out;
  logic [7:0]                 cmd;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ctl       = in_ch.control_value;
  assign on_off    = tmba_pkg::pair_off(ctl[3:2]);
  assign own_off   = tmba_pkg::pair_off(ctl[1:0]);
  assign elapsed_x = tmba_pkg::CMP_W'(elapsed);
  assign forced    = elapsed_x >= tmba_pkg::CMP_W'(force_after);
  assign timed_out = elapsed_x >  tmba_pkg::CMP_W'(give_up_after);
  assign cmd       = tmba_pkg::CMD_TABLE[ctl[3:0]];

  always_comb begin
    acquiring_next = acquiring;
    elapsed_next   = elapsed;
    we_next        = 1'b0;
    data_next      = 8'h00;
    outcome_next   = tmba_pkg::OUT_NONE;
    delay_next     = tmba_pkg::DLY_SHORT;
    unique case (tmba_pkg::mode_t'(in_ch.mode))
      tmba_pkg::MODE_START: begin
        elapsed_next   = '0;
        acquiring_next = 1'b1;
      end
      tmba_pkg::MODE_TICK: begin
        if (elapsed != '1) begin
          elapsed_next = elapsed + 1'b1;
        end
      end
      tmba_pkg::MODE_RELEASE: begin
        acquiring_next = 1'b0;
        if (!in_ch.read_failed && !on_off && own_off) begin
          we_next   = 1'b1;
          data_next = {5'b0, ctl[3], 2'b0};
        end
      end
      tmba_pkg::MODE_POLL: begin
        priority if (!acquiring) begin
          outcome_next = tmba_pkg::OUT_NONE;
        end else if (timed_out) begin
          acquiring_next = 1'b0;
          outcome_next   = tmba_pkg::OUT_TIMEOUT;
        end else if (in_ch.read_failed) begin
          acquiring_next = 1'b0;
          outcome_next   = tmba_pkg::OUT_RDERR;
        end else if (on_off) begin
          outcome_next = tmba_pkg::OUT_RETRY;
          if ((in_ch.status_value & tmba_pkg::ST_OTHER_REQ) == 8'h00 || forced) begin
            we_next    = 1'b1;
            data_next  = cmd | tmba_pkg::CTL_REQ;
            delay_next = tmba_pkg::DLY_SHORT;
          end else begin
            delay_next = tmba_pkg::DLY_XLONG;
          end
        end else if (own_off) begin
          acquiring_next = 1'b0;
          outcome_next   = tmba_pkg::OUT_ACQUIRED;
          if ((ctl & (tmba_pkg::CTL_REQ | tmba_pkg::CTL_INIT)) != 8'h00) begin
            we_next   = 1'b1;
            data_next = ctl & ~(tmba_pkg::CTL_REQ | tmba_pkg::CTL_INIT);
          end
        end else begin
          outcome_next = tmba_pkg::OUT_RETRY;
          delay_next   = tmba_pkg::DLY_LONG;
          priority if (forced) begin
            we_next   = 1'b1;
            data_next = cmd | tmba_pkg::CTL_INIT | tmba_pkg::CTL_REQ;
          end else if ((ctl & tmba_pkg::CTL_REQ) == 8'h00) begin
            we_next   = 1'b1;
            data_next = ctl | tmba_pkg::CTL_REQ;
          end else begin
            we_next = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_after   <= tmba_pkg::FORCE_AFTER_RESET;
      give_up_after <= tmba_pkg::GIVE_UP_AFTER_RESET;
    end else if (cfg_we) begin
      unique case (tmba_pkg::cfg_index_t'(cfg_index))
        tmba_pkg::CFG_FORCE_AFTER:   force_after   <= cfg_data;
        tmba_pkg::CFG_GIVE_UP_AFTER: give_up_after <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acquiring <= 1'b0;
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        acquiring <= acquiring_next;
        elapsed   <= elapsed_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_we      <= we_next;
      out_data    <= data_next;
      out_outcome <= outcome_next;
      out_delay   <= delay_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.write_enable = out_we;
  assign out_ch.write_data   = out_data;
  assign out_ch.outcome      = out_outcome;
  assign out_ch.retry_delay  = out_delay;

endmodule

`default_nettype wire

[tb/sv/two_master_bus_arbiter_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for two_master_bus_arbiter_unit: drives directed and random
// transactions, predicts each reply in a scoreboard class and checks every one in order.
// Depends on tmba_pkg, tmba_if and the unit itself.

module two_master_bus_arbiter_unit_tb;

  localparam int CYCLE_LIMIT = 400_000;

  localparam logic [7:0] REQ_BIT  = 8'h80;
  localparam logic [7:0] INIT_BIT = 8'h10;
  localparam logic [7:0] SEL_CMD [16] = '{
    8'd4, 8'd0, 8'd1, 8'd5, 8'd4, 8'd4, 8'd5, 8'd5,
    8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd4, 8'd5, 8'd1
  };

  typedef struct packed {
    logic               we;
    logic [7:0]         data;
    tmba_pkg::outcome_t oc;
    tmba_pkg::delay_t   dly;
  } reply_t;

  class bus_grant_scoreboard;
    logic [15:0] force_after;
    logic [15:0] give_up_after;
    logic [15:0] elapsed;
    logic        acquiring;
    reply_t      expected_replies[$];
    int          errors;

    function new();
      force_after   = 16'd125;
      give_up_after = 16'd250;
      elapsed       = '0;
      acquiring     = 1'b0;
      errors        = 0;
    endfunction

    function void set_limits(logic [15:0] f, logic [15:0] g);
      force_after   = f;
      give_up_after = g;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function reply_t predict_reply(tmba_pkg::mode_t m, logic [7:0] ctl, logic [7:0] st,
                                   logic rf);
      reply_t r;
      logic   forced;
      r.we   = 1'b0;
      r.data = 8'h00;
      r.oc   = tmba_pkg::OUT_NONE;
      r.dly  = tmba_pkg::DLY_SHORT;
      case (m)
        tmba_pkg::MODE_START: begin
          elapsed   = '0;
          acquiring = 1'b1;
        end
        tmba_pkg::MODE_TICK: begin
          if (elapsed != '1) elapsed++;
        end
        tmba_pkg::MODE_RELEASE: begin
          acquiring = 1'b0;
          if (!rf && ctl[3] != ctl[2] && ctl[1] == ctl[0]) begin
            r.we   = 1'b1;
            r.data = {5'b0, ctl[3], 2'b0};
          end
        end
        default: begin
          if (!acquiring) begin
            r.oc = tmba_pkg::OUT_NONE;
          end else if (elapsed > give_up_after) begin
            acquiring = 1'b0;
            r.oc      = tmba_pkg::OUT_TIMEOUT;
          end else if (rf) begin
            acquiring = 1'b0;
            r.oc      = tmba_pkg::OUT_RDERR;
          end else begin
            forced = elapsed >= force_after;
            r.oc   = tmba_pkg::OUT_RETRY;
            if (ctl[3] == ctl[2]) begin
              // bus off
              if (!st[7] || forced) begin
                r.we   = 1'b1;
                r.data = SEL_CMD[ctl[3:0]] | REQ_BIT;
              end else begin
                r.dly = tmba_pkg::DLY_XLONG;
              end
            end else if (ctl[1] == ctl[0]) begin
              // we own the bus
              acquiring = 1'b0;
              r.oc      = tmba_pkg::OUT_ACQUIRED;
              if ((ctl & (REQ_BIT | INIT_BIT)) != 8'h00) begin
                r.we   = 1'b1;
                r.data = ctl & ~(REQ_BIT | INIT_BIT);
              end
            end else begin
              // other master owns it
              r.dly = tmba_pkg::DLY_LONG;
              if (forced) begin
                r.we   = 1'b1;
                r.data = SEL_CMD[ctl[3:0]] | INIT_BIT | REQ_BIT;
              end else if (!ctl[7]) begin
                r.we   = 1'b1;
                r.data = ctl | REQ_BIT;
              end
            end
          end
        end
      endcase
      return r;
    endfunction

    function void take_request(tmba_pkg::mode_t m, logic [7:0] ctl, logic [7:0] st,
                               logic rf);
      expected_replies.push_back(predict_reply(m, ctl, st, rf));
    endfunction

    task check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected reply we=%0b data=%02h outcome=%0d delay=%0d",
                         got.we, got.data, got.oc, got.dly));
        return;
      end
      want = expected_replies.pop_front();
      if (got.we !== want.we)
        report($sformatf("write_enable got %0b expected %0b", got.we, want.we));
      if (got.data !== want.data)
        report($sformatf("write_data got %02h expected %02h", got.data, want.data));
      if (got.oc !== want.oc)
        report($sformatf("outcome got %0d expected %0d", got.oc, want.oc));
      if (got.dly !== want.dly)
        report($sformatf("retry_delay got %0d expected %0d", got.dly, want.dly));
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [tmba_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tmba_pkg::CFG_W-1:0]       cfg_data;

  tmba_in_if  in_ch();
  tmba_out_if out_ch();

  two_master_bus_arbiter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  bus_grant_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // reply side: check on handshake, then pick next ready
  initial begin
    reply_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.we   = out_ch.write_enable;
        got.data = out_ch.write_data;
        got.oc   = tmba_pkg::outcome_t'(out_ch.outcome);
        got.dly  = tmba_pkg::delay_t'(out_ch.retry_delay);
        sb.check_reply(got);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(tmba_pkg::mode_t m, logic [7:0] ctl, logic [7:0] st, logic rf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= m;
    in_ch.control_value <= ctl;
    in_ch.status_value  <= st;
    in_ch.read_failed   <= rf;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.take_request(m, ctl, st, rf);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(tmba_pkg::MODE_TICK, 8'($urandom), 8'($urandom),
                         1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limits(logic [15:0] f, logic [15:0] g);
    cfg_we    <= 1'b1;
    cfg_index <= tmba_pkg::CFG_FORCE_AFTER;
    cfg_data  <= f;
    @(posedge clk);
    cfg_index <= tmba_pkg::CFG_GIVE_UP_AFTER;
    cfg_data  <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(f, g);
  endtask

  task automatic run_random(int n, int tick_max);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        send_item(tmba_pkg::MODE_START, 8'($urandom), 8'($urandom),
                  1'($urandom_range(1)));
        sent++;
        repeat ($urandom_range(1, 6)) begin
          repeat ($urandom_range(0, tick_max)) begin
            send_ticks(1);
            sent++;
          end
          if ($urandom_range(99) < 8)
            send_item(tmba_pkg::MODE_RELEASE, 8'($urandom), 8'($urandom),
                      $urandom_range(9) == 0);
          else
            send_item(tmba_pkg::MODE_POLL, 8'($urandom), 8'($urandom),
                      $urandom_range(9) == 0);
          sent++;
        end
      end else begin
        send_item(tmba_pkg::mode_t'(2'($urandom_range(3))), 8'($urandom), 8'($urandom),
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= tmba_pkg::CFG_FORCE_AFTER;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= tmba_pkg::MODE_START;
    in_ch.control_value <= 8'h00;
    in_ch.status_value  <= 8'h00;
    in_ch.read_failed   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset limits
    send_item(tmba_pkg::MODE_POLL,    8'h00, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_RELEASE, 8'h08, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_RELEASE, 8'h04, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_RELEASE, 8'h09, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_RELEASE, 8'h08, 8'h00, 1'b1);
    send_item(tmba_pkg::MODE_START,   8'hFF, 8'hFF, 1'b1);
    send_item(tmba_pkg::MODE_POLL,    8'h0F, 8'h80, 1'b0);
    send_item(tmba_pkg::MODE_POLL,    8'h00, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_POLL,    8'h05, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_POLL,    8'h86, 8'h80, 1'b0);
    send_ticks(124);
    send_item(tmba_pkg::MODE_POLL,    8'h00, 8'h80, 1'b0);
    send_ticks(1);
    send_item(tmba_pkg::MODE_POLL,    8'h00, 8'h80, 1'b0);
    send_ticks(125);
    send_item(tmba_pkg::MODE_POLL,    8'h00, 8'h80, 1'b0);
    send_ticks(1);
    send_item(tmba_pkg::MODE_POLL,    8'h00, 8'h80, 1'b0);
    send_item(tmba_pkg::MODE_START,   8'h00, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_POLL,    8'h00, 8'h00, 1'b1);
    drain();

    write_limits(16'd2, 16'd2);
    send_item(tmba_pkg::MODE_START, 8'h00, 8'h00, 1'b0);
    send_ticks(2);
    send_item(tmba_pkg::MODE_POLL,  8'h8A, 8'h80, 1'b0);
    send_item(tmba_pkg::MODE_POLL,  8'hFF, 8'h80, 1'b0);
    send_item(tmba_pkg::MODE_POLL,  8'h94, 8'h7F, 1'b0);
    send_item(tmba_pkg::MODE_START, 8'h00, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_POLL,  8'h07, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_START, 8'h00, 8'h00, 1'b0);
    send_ticks(3);
    send_item(tmba_pkg::MODE_POLL,  8'h00, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_POLL,  8'h00, 8'h00, 1'b0);
    drain();

    // limits at the top of their range
    write_limits(16'hFFFF, 16'hFFFF);
    send_item(tmba_pkg::MODE_START, 8'h00, 8'h00, 1'b0);
    send_item(tmba_pkg::MODE_POLL,  8'h00, 8'h80, 1'b0);
    drain();
    write_limits(16'hFFFF, 16'hFFFE);
    send_item(tmba_pkg::MODE_POLL,  8'h00, 8'h80, 1'b0);
    drain();

    write_limits(16'd5, 16'd9);
    run_random(60, 3);
    drain();

    send_idle_pct = 73;
    write_limits(16'd12, 16'd30);
    run_random(30, 6);
    drain();
    run_random(30, 6);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 73;
    write_limits(16'd0, 16'd0);
    run_random(50, 1);
    drain();

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    write_limits(16'd3, 16'd6);
    run_random(50, 2);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_limits(16'd10, 16'd4);
    run_random(50, 3);
    drain();

    repeat (4) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[two_master_bus_arbiter_unit.f]
hw/rtl/tmba_pkg.sv
hw/rtl/tmba_if.sv
hw/rtl/two_master_bus_arbiter_unit.sv
tb/sv/two_master_bus_arbiter_unit_tb.sv
